[design/rc6_ir_pulse_decoder_core_defines.svh]
// Assertion macros for the RC6 pulse decoder RTL.
`ifndef RC6_IR_PULSE_DECODER_CORE_DEFINES_SVH
`define RC6_IR_PULSE_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RC6D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rc6d assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define RC6D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rc6d assertion failed");
`else
`define RC6D_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RC6D_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/rc6d_pkg.sv]
// Types, constants and the Manchester transition table of the RC6 pulse decoder.
`default_nettype none

package rc6d_pkg;

    localparam int unsigned PULSE_W = 16;
    localparam int unsigned SHIFT_W = 21;
    localparam int unsigned COUNT_W = 5;

    localparam logic [PULSE_W-1:0] UNIT_US   = 16'd222;
    localparam int unsigned        MAX_UNITS = 14;

    // Upper bounds (exclusive) of each duration class in microseconds.
    localparam logic [PULSE_W-1:0] LIM_BAD  = UNIT_US;
    localparam logic [PULSE_W-1:0] LIM_444  = 16'(UNIT_US * 3);
    localparam logic [PULSE_W-1:0] LIM_889  = 16'(UNIT_US * 5);
    localparam logic [PULSE_W-1:0] LIM_1333 = 16'(UNIT_US * 9);
    localparam logic [PULSE_W-1:0] LIM_2666 = 16'(UNIT_US * (MAX_UNITS + 1));

    localparam logic [COUNT_W-1:0] FRAME_BITS = 5'd20;
    localparam logic [COUNT_W-1:0] MODE_BITS  = 5'd3;

    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;

    typedef enum logic [2:0] {
        CL_2666 = 3'd0,
        CL_1333 = 3'd1,
        CL_889  = 3'd2,
        CL_444  = 3'd3,
        CL_BAD  = 3'd4
    } t_pulse_cls;

    typedef enum logic [7:0] {
        B_IDLE = 8'b0000_0001,
        B_LEAD = 8'b0000_0010,
        B_OS   = 8'b0000_0100,
        B_OM   = 8'b0000_1000,
        B_ZM   = 8'b0001_0000,
        B_ZS   = 8'b0010_0000,
        B_TZM  = 8'b0100_0000,
        B_TOM  = 8'b1000_0000
    } t_bit_st;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_LEAD = 4'b0010,
        F_MODE = 4'b0100,
        F_DATA = 4'b1000
    } t_frame_st;

    typedef struct packed {
        logic       too_long;
        t_pulse_cls cls;
    } t_class;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] mode_bits;
        logic       toggle_bit;
        logic [7:0] address_byte;
        logic [7:0] command_byte;
    } t_result;

    // Manchester half-bit transition table, one row per bit state.
    function automatic t_bit_st next_bit(input t_bit_st cur, input t_pulse_cls c);
        t_bit_st nb;
        nb = B_IDLE;
        case (cur)
            B_IDLE: begin
                if (c == CL_2666) nb = B_LEAD;
            end
            B_LEAD: begin
                if (c == CL_889) nb = B_OS;
            end
            B_OS: begin
                if (c == CL_889) nb = B_TOM;
                else if (c == CL_444) nb = B_OM;
            end
            B_OM: begin
                if (c == CL_1333) nb = B_TZM;
                else if (c == CL_889) nb = B_ZM;
                else if (c == CL_444) nb = B_OS;
            end
            B_ZM: begin
                if (c == CL_1333) nb = B_TOM;
                else if (c == CL_889) nb = B_OM;
                else if (c == CL_444) nb = B_ZS;
            end
            B_ZS: begin
                if (c == CL_1333) nb = B_TOM;
                else if (c == CL_889) nb = B_TZM;
                else if (c == CL_444) nb = B_ZM;
            end
            B_TZM: begin
                if (c == CL_1333) nb = B_OM;
                else if (c == CL_889) nb = B_ZS;
            end
            B_TOM: begin
                if (c == CL_1333) nb = B_ZM;
                else if (c == CL_889) nb = B_OS;
            end
            default: nb = B_IDLE;
        endcase
        return nb;
    endfunction

endpackage

`default_nettype wire

[design/rc6d_classify.sv]
// Sorts one pulse duration into its RC6 timing class.
`default_nettype none

module rc6d_classify (
    input  wire logic [rc6d_pkg::PULSE_W-1:0] i_pulse_us,
    output rc6d_pkg::t_class                  o_class
);

    // Bounds are whole multiples of the 222 us unit, so comparing the raw
    // duration gives the same answer as dividing it into units first.
    always_comb begin
        o_class.too_long = (i_pulse_us >= rc6d_pkg::LIM_2666);
        if (i_pulse_us < rc6d_pkg::LIM_BAD) begin
            o_class.cls = rc6d_pkg::CL_BAD;
        end else if (i_pulse_us < rc6d_pkg::LIM_444) begin
            o_class.cls = rc6d_pkg::CL_444;
        end else if (i_pulse_us < rc6d_pkg::LIM_889) begin
            o_class.cls = rc6d_pkg::CL_889;
        end else if (i_pulse_us < rc6d_pkg::LIM_1333) begin
            o_class.cls = rc6d_pkg::CL_1333;
        end else begin
            o_class.cls = rc6d_pkg::CL_2666;
        end
    end

endmodule

`default_nettype wire

[design/rc6d_frame.sv]
// Bit and frame state machines with the frame shift register.
`default_nettype none

`include "rc6_ir_pulse_decoder_core_defines.svh"

module rc6d_frame (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire rc6d_pkg::t_class i_class,
    output rc6d_pkg::t_result     o_res
);

    rc6d_pkg::t_bit_st                   r_bit, n_bit;
    rc6d_pkg::t_frame_st                 r_frame, n_frame;
    logic [rc6d_pkg::SHIFT_W-1:0]        r_shift, n_shift;
    logic [rc6d_pkg::COUNT_W-1:0]        r_bits, n_bits;
    rc6d_pkg::t_bit_st                   bp;
    logic                                is_one;
    logic                                is_mid;
    logic                                is_trail;
    logic                                done;

    always_comb begin
        bp       = rc6d_pkg::next_bit(r_bit, i_class.cls);
        is_one   = (bp == rc6d_pkg::B_OM) || (bp == rc6d_pkg::B_TOM);
        is_mid   = (bp == rc6d_pkg::B_OM) || (bp == rc6d_pkg::B_ZM);
        is_trail = (bp == rc6d_pkg::B_TOM) || (bp == rc6d_pkg::B_TZM);
        n_bit    = r_bit;
        n_frame  = r_frame;
        n_shift  = r_shift;
        n_bits   = r_bits;
        done     = 1'b0;
        if (i_step && !i_class.too_long) begin
            n_bit = bp;
            // Start halves of a bit pair leave the frame machine alone.
            if ((bp != rc6d_pkg::B_OS) && (bp != rc6d_pkg::B_ZS)) begin
                n_frame = rc6d_pkg::F_IDLE;
                case (r_frame)
                    rc6d_pkg::F_IDLE: begin
                        if (bp == rc6d_pkg::B_LEAD) begin
                            n_bits  = '0;
                            n_frame = rc6d_pkg::F_LEAD;
                        end
                    end
                    rc6d_pkg::F_LEAD: begin
                        if (bp == rc6d_pkg::B_OM) begin
                            n_shift = {{(rc6d_pkg::SHIFT_W-1){1'b0}}, 1'b1};
                            n_frame = rc6d_pkg::F_MODE;
                        end
                    end
                    rc6d_pkg::F_MODE: begin
                        if (is_mid && (r_bits < rc6d_pkg::MODE_BITS)) begin
                            n_shift = {r_shift[rc6d_pkg::SHIFT_W-2:0], is_one};
                            n_bits  = r_bits + 5'd1;
                            n_frame = rc6d_pkg::F_MODE;
                        end else if (is_trail && (r_bits == rc6d_pkg::MODE_BITS)) begin
                            n_shift = {r_shift[rc6d_pkg::SHIFT_W-2:0], is_one};
                            n_bits  = r_bits + 5'd1;
                            n_frame = rc6d_pkg::F_DATA;
                        end
                    end
                    rc6d_pkg::F_DATA: begin
                        if (is_mid && (r_bits < rc6d_pkg::FRAME_BITS)) begin
                            n_shift = {r_shift[rc6d_pkg::SHIFT_W-2:0], is_one};
                            n_bits  = r_bits + 5'd1;
                            n_frame = rc6d_pkg::F_DATA;
                            done    = (r_bits == (rc6d_pkg::FRAME_BITS - 5'd1));
                        end
                    end
                    default: n_frame = rc6d_pkg::F_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (i_class.too_long) begin
            o_res.status = rc6d_pkg::ST_LONG;
        end else if (done) begin
            o_res.status       = rc6d_pkg::ST_FRAME;
            o_res.mode_bits    = n_shift[19:17];
            o_res.toggle_bit   = n_shift[16];
            o_res.address_byte = n_shift[15:8];
            o_res.command_byte = n_shift[7:0];
        end else begin
            o_res.status = rc6d_pkg::ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit   <= rc6d_pkg::B_IDLE;
            r_frame <= rc6d_pkg::F_IDLE;
            r_shift <= '0;
            r_bits  <= '0;
        end else begin
            r_bit   <= n_bit;
            r_frame <= n_frame;
            r_shift <= n_shift;
            r_bits  <= n_bits;
        end
    end

    `RC6D_ASSERT_IMP(a_bits_bound, i_clk, i_rst_n, 1'b1, r_bits <= rc6d_pkg::FRAME_BITS)
    `RC6D_ASSERT_IMP(a_mode_bound, i_clk, i_rst_n, r_frame == rc6d_pkg::F_MODE,
        r_bits <= rc6d_pkg::MODE_BITS)
    `RC6D_ASSERT_NXT(a_done_state, i_clk, i_rst_n, i_step && done,
        (r_frame == rc6d_pkg::F_DATA) && (r_bits == rc6d_pkg::FRAME_BITS))
    `RC6D_ASSERT_NXT(a_long_hold, i_clk, i_rst_n, i_step && i_class.too_long,
        $stable(r_bit) && $stable(r_frame) && $stable(r_bits))

endmodule

`default_nettype wire

[design/rc6_ir_pulse_decoder_core.sv]
// Top level of the RC6 mode-0 infrared pulse decoder.
//
// Usage: each input transaction carries the duration of one IR mark or space
// in microseconds on i_pulse_us, offered with i_valid and held off by o_stall.
// Every input transaction yields exactly one output transaction on o_valid /
// i_stall: o_status is 0 for nothing, 1 when a frame has just completed (its
// mode, toggle, address and command fields are then valid, zero otherwise)
// and 2 for a pulse of fifteen or more 222 us units, which changes nothing.
// An accepted pulse first loads the input register; the classifier, the
// Manchester table step and the frame step then run on it and load the
// result register. Throughput is one transaction per cycle unless the
// receiver stalls; the bit and frame state is a single register update,
// so consecutive pulses follow back to back.
// When the receiver stalls, the finished result holds in the output register
// and the input register still takes one more pulse; after that o_stall rises
// until the output drains. Synchronous active-low reset empties both
// registers and returns the decoder to idle with no frame in progress.
`default_nettype none

module rc6_ir_pulse_decoder_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [rc6d_pkg::PULSE_W-1:0]  i_pulse_us,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_status,
    output logic [2:0]                         o_mode_bits,
    output logic                               o_toggle_bit,
    output logic [7:0]                         o_address_byte,
    output logic [7:0]                         o_command_byte
);

    logic                            r_in_valid;
    logic [rc6d_pkg::PULSE_W-1:0]    r_pulse;
    logic                            r_out_valid;
    rc6d_pkg::t_result               r_res;
    rc6d_pkg::t_class                cls;
    rc6d_pkg::t_result               res;
    logic                            out_adv;
    logic                            step;
    logic                            in_take;

    // The output register can load when empty or when its transaction leaves.
    assign out_adv = !r_out_valid || !i_stall;
    assign step    = r_in_valid && out_adv;
    assign o_stall = r_in_valid && !out_adv;
    assign in_take = i_valid && !o_stall;

    rc6d_classify u_classify (
        .i_pulse_us (r_pulse),
        .o_class    (cls)
    );

    rc6d_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_class (cls),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pulse <= i_pulse_us;
        end
        if (step) begin
            r_res <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_res.status;
    assign o_mode_bits    = r_res.mode_bits;
    assign o_toggle_bit   = r_res.toggle_bit;
    assign o_address_byte = r_res.address_byte;
    assign o_command_byte = r_res.command_byte;

endmodule

`default_nettype wire
